// ----- src/poker_test_statistic_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the poker test statistic core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POKER_TEST_STATISTIC_CORE_MACROS_SVH
`define POKER_TEST_STATISTIC_CORE_MACROS_SVH

// same-cycle implication
`define PTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Types, constants and helpers shared by the poker test statistic core.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MAX_SEQ_BITS_DEF   = 1048576;
  localparam int MAX_GROUP_BITS_DEF = 8;
  localparam int TBL_W              = 8;    // widest pattern index
  localparam int QUEUE_DEPTH        = 4;
  localparam logic [3:0] GROUP_BITS_RST = 4'd4;

  typedef struct packed {
    logic bit_value;
    logic last;
  } in_t;

  typedef struct packed {
    logic [40:0] sum_squares;
    logic [20:0] group_count;
    logic [42:0] scaled_statistic;
    logic        too_long;
  } out_t;

  // command from front to back
  typedef struct packed {
    logic             cnt_en;   // count pattern idx
    logic [TBL_W-1:0] idx;
    logic             fin;      // end of sequence, emit result
    logic [3:0]       m;        // group size at the last bit
    logic             too_long;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_STAT1,
    ST_STAT2,
    ST_FIN
  } st_t;

  // group size as used: zero means one, clipped to the table size
  function automatic logic [3:0] eff_m(logic [3:0] gb, logic [3:0] mx);
    logic [3:0] m;
    if (gb == 4'd0) begin
      m = 4'd1;
    end else if (gb > mx) begin
      m = mx;
    end else begin
      m = gb;
    end
    return m;
  endfunction

endpackage

// ----- src/pts_front.sv -----
// ----------------------------------------------------------------------------
// pts_front
// Accepts bits, packs them into groups and issues count / finish commands.
// ----------------------------------------------------------------------------
module pts_front #(
  parameter int MAX_SEQ_BITS   = pts_pkg::MAX_SEQ_BITS_DEF,
  parameter int MAX_GROUP_BITS = pts_pkg::MAX_GROUP_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  pts_pkg::in_t  in_data,
  input  logic          q_full,
  output logic          q_push,
  output pts_pkg::cmd_t q_data
);

  localparam int CNT_W = $clog2(MAX_SEQ_BITS + 1);
  localparam int IDX_W = MAX_GROUP_BITS;

  logic [3:0]       gb_r;
  logic [IDX_W-1:0] shift_r, shift_nxt;
  logic [3:0]       bits_r, bits_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic             ovf_r, ovf_nxt;

  logic             acc;
  logic [3:0]       m;
  logic [IDX_W-1:0] mask;
  logic [IDX_W-1:0] sh;
  logic [3:0]       big;
  pts_pkg::cmd_t    cmd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign acc       = in_valid && !q_full;
  assign m         = pts_pkg::eff_m(gb_r, 4'(MAX_GROUP_BITS));
  assign mask      = IDX_W'((9'd1 << m) - 9'd1);

  always_comb begin
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    cmd       = '0;
    sh        = IDX_W'({shift_r, in_data.bit_value});
    big       = bits_r + 4'd1;
    if (acc) begin
      if (seen_r < CNT_W'(MAX_SEQ_BITS)) begin
        seen_nxt = seen_r + 1'b1;
        if (big >= m) begin
          cmd.cnt_en = 1'b1;
          cmd.idx    = (pts_pkg::TBL_W)'(sh & mask);
          shift_nxt  = '0;
          bits_nxt   = 4'd0;
        end else begin
          shift_nxt = sh;
          bits_nxt  = big;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_data.last) begin
        cmd.fin      = 1'b1;
        cmd.m        = m;
        cmd.too_long = ovf_nxt;
        shift_nxt    = '0;
        bits_nxt     = 4'd0;
        seen_nxt     = '0;
        ovf_nxt      = 1'b0;
      end
    end
  end

  assign q_push = acc && (cmd.cnt_en || cmd.fin);
  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gb_r    <= pts_pkg::GROUP_BITS_RST;
      shift_r <= '0;
      bits_r  <= 4'd0;
      seen_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        gb_r <= cfg_data;
      end
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ----- src/pts_queue.sv -----
// ----------------------------------------------------------------------------
// pts_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module pts_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pts_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_vld,
  output pts_pkg::cmd_t q_data
);

  localparam int DEPTH = pts_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pts_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign q_vld   = (cnt_r != '0);
  assign q_data  = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- src/pts_back.sv -----
// ----------------------------------------------------------------------------
// pts_back
// Histogram update, final walk with sum of squares, statistic and result.
// ----------------------------------------------------------------------------
module pts_back #(
  parameter int MAX_SEQ_BITS   = pts_pkg::MAX_SEQ_BITS_DEF,
  parameter int MAX_GROUP_BITS = pts_pkg::MAX_GROUP_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_vld,
  input  pts_pkg::cmd_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output pts_pkg::out_t out_data
);

  localparam int CNT_W  = $clog2(MAX_SEQ_BITS + 1);
  localparam int IDX_W  = MAX_GROUP_BITS;
  localparam int DEPTH  = 1 << IDX_W;
  localparam int SUM_W  = 2 * CNT_W;
  localparam int STAT_W = SUM_W + MAX_GROUP_BITS;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  pts_pkg::st_t     state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;

  logic             iss_vld, iss_inc;
  logic [IDX_W-1:0] iss_addr;
  logic             fin_ld, n2_ld, stat_ld, out_ld;

  logic             b_vld_r, b_inc_r, b_rdv_r;
  logic [IDX_W-1:0] b_addr_r;
  logic [CNT_W-1:0] rd_q_r;
  logic             wr_vld_r;
  logic [IDX_W-1:0] wr_addr_r;
  logic [CNT_W-1:0] wr_data_r;
  logic             c_vld_r, d_vld_r;
  logic [CNT_W-1:0] cur_r;
  logic [SUM_W-1:0] sq_r;

  logic [3:0]        fin_m_r;
  logic              fin_tl_r;
  logic [CNT_W-1:0]  groups_r;
  logic [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]  n2_r;
  logic [STAT_W-1:0] stat_r;
  logic [STAT_W-1:0] scaled;
  logic [STAT_W-1:0] n2_ext;

  logic              out_vld_r;
  pts_pkg::out_t     out_data_r;

  logic             fwd, we;
  logic [CNT_W-1:0] val;

  // previous cycle's write is not yet visible in the read data
  assign fwd = wr_vld_r && (wr_addr_r == b_addr_r);
  assign val = fwd ? wr_data_r : (b_rdv_r ? rd_q_r : '0);
  assign we  = b_vld_r && b_inc_r;

  assign scaled = STAT_W'(acc_r) << fin_m_r;
  assign n2_ext = STAT_W'(n2_r);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pop       = 1'b0;
    iss_vld   = 1'b0;
    iss_inc   = 1'b0;
    iss_addr  = k_r;
    fin_ld    = 1'b0;
    n2_ld     = 1'b0;
    stat_ld   = 1'b0;
    out_ld    = 1'b0;
    case (state_r)
      pts_pkg::ST_IDLE: begin
        if (q_vld) begin
          pop = 1'b1;
          if (q_data.cnt_en) begin
            iss_vld  = 1'b1;
            iss_inc  = 1'b1;
            iss_addr = q_data.idx[IDX_W-1:0];
          end
          if (q_data.fin) begin
            fin_ld    = 1'b1;
            k_nxt     = '0;
            state_nxt = pts_pkg::ST_WALK;
          end
        end
      end
      pts_pkg::ST_WALK: begin
        iss_vld = 1'b1;
        k_nxt   = k_r + 1'b1;
        if (k_r == '1) begin
          state_nxt = pts_pkg::ST_DRAIN;
        end
      end
      pts_pkg::ST_DRAIN: begin
        if (!b_vld_r && !c_vld_r && !d_vld_r) begin
          state_nxt = pts_pkg::ST_STAT1;
        end
      end
      pts_pkg::ST_STAT1: begin
        n2_ld     = 1'b1;
        state_nxt = pts_pkg::ST_STAT2;
      end
      pts_pkg::ST_STAT2: begin
        stat_ld   = 1'b1;
        state_nxt = pts_pkg::ST_FIN;
      end
      pts_pkg::ST_FIN: begin
        if (!out_vld_r || out_ready) begin
          out_ld    = 1'b1;
          state_nxt = pts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pts_pkg::ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // histogram memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[b_addr_r] <= val + 1'b1;
    end
    rd_q_r <= mem[iss_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      wr_vld_r  <= 1'b0;
      groups_r  <= '0;
      acc_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      b_vld_r  <= iss_vld;
      c_vld_r  <= b_vld_r && !b_inc_r;
      d_vld_r  <= c_vld_r;
      wr_vld_r <= we;
      if (out_ld) begin
        vld_r    <= '0;
        groups_r <= '0;
        acc_r    <= '0;
      end else begin
        if (we) begin
          vld_r[b_addr_r] <= 1'b1;
        end
        if (iss_vld && iss_inc) begin
          groups_r <= groups_r + 1'b1;
        end
        if (d_vld_r) begin
          acc_r <= acc_r + sq_r;
        end
      end
      if (out_ld) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_inc_r   <= iss_inc;
    b_addr_r  <= iss_addr;
    b_rdv_r   <= vld_r[iss_addr];
    wr_addr_r <= b_addr_r;
    wr_data_r <= val + 1'b1;
    cur_r     <= val;
    sq_r      <= cur_r * cur_r;
    if (fin_ld) begin
      fin_m_r  <= q_data.m;
      fin_tl_r <= q_data.too_long;
    end
    if (n2_ld) begin
      n2_r <= groups_r * groups_r;
    end
    if (stat_ld) begin
      // saturate at zero after a mid-sequence group size change
      stat_r <= (scaled >= n2_ext) ? (scaled - n2_ext) : '0;
    end
    if (out_ld) begin
      out_data_r.sum_squares      <= 41'(acc_r);
      out_data_r.group_count      <= 21'(groups_r);
      out_data_r.scaled_statistic <= 43'(stat_r);
      out_data_r.too_long         <= fin_tl_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/poker_test_statistic_core.sv -----
// Throughput: one bit per cycle while the command queue has room.
// A result follows a walk of all histogram entries once the last-bit command leaves
// the queue; the walk reads one histogram entry a cycle through the memory port.
// Input stalls during that walk once the four-entry queue fills.
// Reset: synchronous, active low; clears control state and the histogram valid bits,
// so no clearing pass is needed. group_bits resets to 4.
// ----------------------------------------------------------------------------
// poker_test_statistic_core
// Poker test histogram and scaled statistic over a serial bit sequence.
// ----------------------------------------------------------------------------
module poker_test_statistic_core #(
  parameter int MAX_SEQ_BITS   = pts_pkg::MAX_SEQ_BITS_DEF,
  parameter int MAX_GROUP_BITS = pts_pkg::MAX_GROUP_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  pts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pts_pkg::out_t out_data
);

  logic          q_push, q_full, q_pop, q_vld;
  pts_pkg::cmd_t q_wdata, q_rdata;

  pts_front #(
    .MAX_SEQ_BITS   (MAX_SEQ_BITS),
    .MAX_GROUP_BITS (MAX_GROUP_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  pts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .q_vld     (q_vld),
    .q_data    (q_rdata)
  );

  pts_back #(
    .MAX_SEQ_BITS   (MAX_SEQ_BITS),
    .MAX_GROUP_BITS (MAX_GROUP_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_data    (q_rdata),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker
// Port-level assertions for the poker test statistic core, bound to the top.
// ----------------------------------------------------------------------------
`include "poker_test_statistic_core_macros.svh"

module pts_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          cfg_valid,
  input logic          cfg_ready,
  input logic          in_valid,
  input logic          in_ready,
  input pts_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input pts_pkg::out_t out_data
);

  logic [41:0] n_sq;
  logic        out_stall;
  logic        in_stall;
  logic        no_groups;
  logic        zero_res;
  logic        sum_ok;

  assign n_sq      = out_data.group_count * out_data.group_count;
  assign out_stall = out_valid && !out_ready;
  assign in_stall  = in_valid && !in_ready;
  assign no_groups = out_valid && (out_data.group_count == 21'd0);
  assign zero_res  = (out_data.sum_squares == 41'd0) && (out_data.scaled_statistic == 43'd0);
  assign sum_ok    = ({1'b0, out_data.sum_squares} <= n_sq);

  // a stalled result holds
  `PTS_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // a stalled input transaction holds
  `PTS_ASSERT_NXT(a_in_hold, in_stall, in_valid && $stable(in_data), "input changed while stalled")

  // configuration port never back-pressures
  `PTS_ASSERT_IMP(a_cfg_rdy, cfg_valid, cfg_ready, "config port not ready")

  // no groups means an all-zero histogram and statistic
  `PTS_ASSERT_IMP(a_empty, no_groups, zero_res, "nonzero result without groups")

  // sum of squared counts never exceeds the squared group count
  `PTS_ASSERT_IMP(a_sum_bound, out_valid, sum_ok, "sum of squares above N squared")

endmodule

bind poker_test_statistic_core pts_checker u_pts_checker (.*);

// ----- test/poker_test_statistic_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poker_test_statistic_core_test
// Drives bit sequences through the poker statistic core and checks each result
// transaction against a cycle-free software tally of the pattern histogram.
// A directed table runs first, then random sequences over many group sizes.
// ----------------------------------------------------------------------------
module poker_test_statistic_core_test;

  localparam int SEQ_LIMIT   = pts_pkg::MAX_SEQ_BITS_DEF;
  localparam int LONG_RUN    = 205;
  localparam int GROUP_MAX   = pts_pkg::MAX_GROUP_BITS_DEF;
  localparam int DRAIN_WAIT  = (1 << GROUP_MAX) + 7 + pts_pkg::QUEUE_DEPTH + 40;
  localparam int RANDOM_BITS = 1450;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 1500;

  typedef enum logic {ROW_CFG, ROW_BITS} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [3:0]    gbits;
    logic [63:0]   word;     // sent msb first, nbits wide
    int            nbits;
    int            reps;
    logic          last;     // on the final bit of the final repeat
    logic          typed;
    pts_pkg::out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = 4'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  pts_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pts_pkg::out_t out_data;

  // software tally of the block
  int unsigned hist_count [1 << GROUP_MAX];
  logic [7:0]  pack_reg;
  logic [3:0]  pack_fill;
  int          group_total;
  int          bit_total;
  logic        dropped_flag;
  logic [3:0]  group_size_reg;

  pts_pkg::out_t pending_stats[$];
  stim_row_t     directed_rows[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          random_sent = 0;

  // receiver state
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  logic [15:0] stall_pat = 16'hF3A5;

  poker_test_statistic_core #(
    .MAX_SEQ_BITS(SEQ_LIMIT),
    .MAX_GROUP_BITS(GROUP_MAX)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [3:0] group_size_used();
    if (group_size_reg == 4'd0) begin
      return 4'd1;
    end
    if (group_size_reg > 4'(GROUP_MAX)) begin
      return 4'(GROUP_MAX);
    end
    return group_size_reg;
  endfunction

  task automatic clear_tally();
    foreach (hist_count[k]) hist_count[k] = 0;
    pack_reg = '0;
    pack_fill = '0;
    group_total = 0;
    bit_total = 0;
    dropped_flag = 1'b0;
  endtask

  // one accepted bit; returns the statistic when the bit closes the sequence
  task automatic tally_bit(input pts_pkg::in_t it, output logic fired,
                           output pts_pkg::out_t res);
    logic [3:0]  m;
    logic [7:0]  mask;
    logic [63:0] acc;
    logic [63:0] scaled;
    logic [63:0] n_sq;
    m = group_size_used();
    mask = 8'((9'd1 << m) - 9'd1);
    fired = 1'b0;
    res = '0;
    if (bit_total < SEQ_LIMIT) begin
      bit_total++;
      pack_reg = {pack_reg[6:0], it.bit_value};
      pack_fill = pack_fill + 4'd1;
      // a partial group at or above the new size closes at once
      if (pack_fill >= m) begin
        hist_count[pack_reg & mask]++;
        group_total++;
        pack_fill = '0;
        pack_reg = '0;
      end
    end else begin
      dropped_flag = 1'b1;
    end
    if (it.last) begin
      acc = '0;
      foreach (hist_count[k]) acc += 64'(hist_count[k]) * 64'(hist_count[k]);
      scaled = acc << m;
      n_sq = 64'(group_total) * 64'(group_total);
      res.sum_squares = acc[40:0];
      res.group_count = 21'(group_total);
      res.scaled_statistic = (scaled >= n_sq) ? 43'(scaled - n_sq) : 43'd0;
      res.too_long = dropped_flag;
      fired = 1'b1;
      clear_tally();
    end
  endtask

  // present one bit with bursty pacing; tally it once the transaction completes
  task automatic offer(input pts_pkg::in_t it, input logic typed,
                       input pts_pkg::out_t want);
    logic          fired;
    pts_pkg::out_t res;
    int            gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0: gap = $urandom_range(15, 60);
        1, 2, 3: gap = 0;
        default: gap = $urandom_range(1, 6);
      endcase
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tally_bit(it, fired, res);
    if (fired) begin
      pending_stats.push_back(typed ? want : res);
    end
  endtask

  // only written with no result outstanding and the pipeline given time to empty
  task automatic write_group_bits(input logic [3:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    group_size_reg = value;
  endtask

  function automatic stim_row_t cfg_row(input logic [3:0] value);
    stim_row_t r;
    r = '{kind: ROW_CFG, gbits: value, word: '0, nbits: 0, reps: 0, last: 1'b0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t bit_row(input logic [63:0] word, input int nbits,
                                        input int reps, input logic last,
                                        input logic typed, input pts_pkg::out_t want);
    stim_row_t r;
    r = '{kind: ROW_BITS, gbits: 4'd0, word: word, nbits: nbits, reps: reps,
          last: last, typed: typed, want: want};
    return r;
  endfunction

  // result side: stall pattern, one long hold-off, and the comparison
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result transaction %0d: sum %0d n %0d stat %0d long %0b",
                   results_seen, out_data.sum_squares, out_data.group_count,
                   out_data.scaled_statistic, out_data.too_long);
        end
      end else begin
        pts_pkg::out_t want;
        want = pending_stats.pop_front();
        if (out_data.sum_squares !== want.sum_squares ||
            out_data.group_count !== want.group_count ||
            out_data.scaled_statistic !== want.scaled_statistic ||
            out_data.too_long !== want.too_long) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d mismatch (expected/actual): sum %0d/%0d n %0d/%0d",
                     results_seen, want.sum_squares, out_data.sum_squares,
                     want.group_count, out_data.group_count);
            $display("  stat %0d/%0d too_long %0b/%0b",
                     want.scaled_statistic, out_data.scaled_statistic,
                     want.too_long, out_data.too_long);
          end
        end
      end
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(50, 400);
      end else begin
        rx_mode_left--;
      end
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= stall_pat[0];
      endcase
    end
  end

  initial begin
    pts_pkg::in_t it;
    stim_row_t    row;
    int           phase;
    int           nseq;
    int           len;
    int           style;
    logic [7:0]   motif;
    logic         close;

    group_size_reg = pts_pkg::GROUP_BITS_RST;
    clear_tally();

    // single bit, no complete group, right after reset, group size four
    directed_rows.push_back(bit_row(64'h0, 1, 1, 1'b1, 1'b1, '0));
    directed_rows.push_back(bit_row(64'hF, 4, 1, 1'b1, 1'b1,
      '{sum_squares: 41'd1, group_count: 21'd1, scaled_statistic: 43'd15, too_long: 1'b0}));
    // zero group size acts as one
    directed_rows.push_back(cfg_row(4'd0));
    directed_rows.push_back(bit_row(64'b11110, 5, 1, 1'b1, 1'b0, '0));
    // above the table size clips to eight
    directed_rows.push_back(cfg_row(4'd15));
    directed_rows.push_back(bit_row(64'hFF, 8, 1, 1'b1, 1'b1,
      '{sum_squares: 41'd1, group_count: 21'd1, scaled_statistic: 43'd255, too_long: 1'b0}));
    directed_rows.push_back(cfg_row(4'd8));
    directed_rows.push_back(bit_row(64'h0, 16, 1, 1'b1, 1'b0, '0));
    directed_rows.push_back(bit_row(64'hA5C3_0F96_1E78_D24B, 64, 1, 1'b0, 1'b0, '0));
    directed_rows.push_back(bit_row(64'b101, 3, 1, 1'b1, 1'b0, '0));
    // size drops below a partial group: it closes on the next bit
    directed_rows.push_back(bit_row(64'b10110, 5, 1, 1'b0, 1'b0, '0));
    directed_rows.push_back(cfg_row(4'd2));
    directed_rows.push_back(bit_row(64'b1100, 4, 1, 1'b1, 1'b0, '0));
    // wide spread at eight, scaled by four at the end: statistic saturates
    directed_rows.push_back(cfg_row(4'd8));
    directed_rows.push_back(bit_row(64'h01_02_03_04_05, 40, 1, 1'b0, 1'b0, '0));
    directed_rows.push_back(cfg_row(4'd2));
    directed_rows.push_back(bit_row(64'h1, 1, 1, 1'b1, 1'b1,
      '{sum_squares: 41'd5, group_count: 21'd5, scaled_statistic: 43'd0, too_long: 1'b0}));
    // long run of ones at size one: statistic equals N squared
    directed_rows.push_back(cfg_row(4'd1));
    directed_rows.push_back(bit_row(64'h1, 1, LONG_RUN, 1'b1, 1'b1,
      '{sum_squares: 41'(LONG_RUN * LONG_RUN), group_count: 21'(LONG_RUN),
        scaled_statistic: 43'(LONG_RUN * LONG_RUN), too_long: 1'b0}));
    directed_rows.push_back(cfg_row(4'd9));
    directed_rows.push_back(bit_row(64'h6D_B2_9E, 24, 1, 1'b1, 1'b0, '0));
    directed_rows.push_back(cfg_row(4'd4));
    directed_rows.push_back(bit_row(64'b111, 3, 1, 1'b1, 1'b1, '0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_group_bits(row.gbits);
      end else begin
        for (int r = 0; r < row.reps; r++) begin
          for (int b = row.nbits - 1; b >= 0; b--) begin
            it.bit_value = row.word[b];
            it.last = row.last && (r == row.reps - 1) && (b == 0);
            offer(it, row.typed && it.last, row.want);
          end
        end
      end
    end

    phase = 0;
    while (random_sent < RANDOM_BITS) begin
      case (phase)
        0: write_group_bits(4'd1);
        1: write_group_bits(4'd8);
        2: write_group_bits(4'd0);
        3: write_group_bits(4'd15);
        default: write_group_bits(4'($urandom_range(0, 15)));
      endcase
      if (phase == 2) begin
        hold_armed = 1'b1;
      end
      nseq = $urandom_range(2, 6);
      for (int s = 0; s < nseq; s++) begin
        case ($urandom_range(0, 19))
          0: len = $urandom_range(LONG_RUN - 8, LONG_RUN + 24);
          1: len = $urandom_range(1, 3);
          default: len = $urandom_range(1, 72);
        endcase
        style = $urandom_range(0, 9);
        motif = 8'($urandom_range(0, 255));
        // sometimes leave the sequence open so the next size change lands mid-stream
        close = !((s == nseq - 1) && ($urandom_range(0, 3) == 0));
        for (int k = 0; k < len; k++) begin
          case (style)
            0: it.bit_value = 1'b1;
            1: it.bit_value = 1'b0;
            2: it.bit_value = motif[k % 8];
            default: it.bit_value = 1'($urandom_range(0, 1));
          endcase
          it.last = close && (k == len - 1);
          offer(it, 1'b0, '0);
          random_sent++;
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
